/* hdl/mpa_pkg.sv */
// Package for the 2-D max pooling block with argmax.
// Holds the register indexes and the sequencer state type; no dependencies.
package mpa_pkg;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 11;

	localparam logic [CFG_IDX_BITS-1:0] REG_IN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_W  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_H  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_W  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_H  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_COUNT     = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

/* hdl/mpa_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/max_pool_2d_argmax.sv */
// Top level of the 2-D max pooling block with argmax over one plane.
// Depends on mpa_pkg and mpa_ram (line store).
//
// Usage:
//   Samples enter on the s_ channel in raster order; s_tuser high marks the
//   first sample of a plane. Every sample inside the plane is written to a line store of
//   MAX_KERNEL rows. A sample that closes a pooling window starts a scan of
//   the window through the store's read port, one stored sample per cycle.
//   Results leave on the m_ channel: tdata carries the maximum, its 1-based
//   column and row in the window and the output column and row; tlast marks
//   the last window of the plane.
//   Samples that close no window are taken one per cycle while idle. A window
//   sample holds s_tready low through the scan (SCAN), the FLUSH of the last
//   read and EMIT, until its result is loaded into the output register.
//   A result waits in the output register while the next samples are taken;
//   a further window waits at the end of its scan until that register frees.
//   Configuration writes on the cfg_ channel are always ready, are meant for
//   an idle block; a valid index restarts the position at row 0, column 0.
//   Reset loads the default registers (32 x 32 plane, 2 x 2 window, stride 2)
//   and clears the position; the line store is not cleared.
module max_pool_2d_argmax #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_KERNEL  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
	input  logic                                   s_tuser,   // plane_start
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// max_value, arg_col[3:0], arg_row[3:0], out_col[9:0], out_row[9:0]
	output logic [((SAMPLE_BITS+28+7)/8)*8-1:0]    m_tdata,
	output logic                                   m_tlast,   // plane_last
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mpa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [mpa_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int KB    = $clog2(MAX_KERNEL + 1);
	localparam int CB    = 13;
	localparam int OTW   = ((SAMPLE_BITS + 28 + 7) / 8) * 8;

	logic [10:0] in_width_q, in_height_q;
	logic [3:0]  kernel_w_q, kernel_h_q, stride_w_q, stride_h_q;

	logic [10:0] w, h;
	logic [KB-1:0] kw, kh;
	logic [3:0] sw, sh;

	logic [XW-1:0] col_pos_q;
	logic [3:0]    cph_q;
	logic [9:0]    oc_q;
	logic [10:0]   row_pos_q;
	logic [3:0]    rph_q;
	logic [9:0]    orow_q;
	logic [AW-1:0] rbase_q;

	logic [XW-1:0] c_e;
	logic [3:0]    cph_e, rph_e;
	logic [9:0]    oc_e, orow_e;
	logic [10:0]   r_e;
	logic [AW-1:0] rbase_e;
	logic          col_rst, drop, col_wrap, win, cfg_wr, accept;
	logic [CB-1:0] c_nx;
	logic [AW:0]   koff, wstart, rb_nx;

	mpa_pkg::state_t state_q, state_d;

	logic [XW-1:0]  c0_q;
	logic [AW-1:0]  row_addr_q;
	logic [KB-1:0]  kx_q, ky_q;
	logic [9:0]     win_ocol_q, win_orow_q;
	logic           win_last_q;
	logic [AW:0]    ra_nx;
	logic           kx_end, ky_end;

	logic           vld_s1;
	logic [KB-1:0]  kx_s1, ky_s1;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [AW-1:0]  rd_addr;

	logic [SAMPLE_BITS-1:0] best_q;
	logic [KB-1:0]  bkx_q, bky_q;

	logic                   m_valid_q;
	logic [SAMPLE_BITS-1:0] o_max_q;
	logic [3:0]             o_acol_q, o_arow_q;
	logic [9:0]             o_ocol_q, o_orow_q;
	logic                   o_last_q;
	logic                   out_load;

	// effective register values
	always_comb begin
		if (in_width_q == 11'd0) begin
			w = 11'd1;
		end else if (32'(in_width_q) > MAX_WIDTH) begin
			w = 11'(MAX_WIDTH);
		end else begin
			w = in_width_q;
		end
		h = (in_height_q == 11'd0) ? 11'd1 : in_height_q;
		if (kernel_w_q == 4'd0) begin
			kw = KB'(1);
		end else if (32'(kernel_w_q) > MAX_KERNEL) begin
			kw = KB'(MAX_KERNEL);
		end else begin
			kw = KB'(kernel_w_q);
		end
		if (kernel_h_q == 4'd0) begin
			kh = KB'(1);
		end else if (32'(kernel_h_q) > MAX_KERNEL) begin
			kh = KB'(MAX_KERNEL);
		end else begin
			kh = KB'(kernel_h_q);
		end
		sw = (stride_w_q == 4'd0) ? 4'd1 : stride_w_q;
		sh = (stride_h_q == 4'd0) ? 4'd1 : stride_h_q;
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_index < mpa_pkg::REG_COUNT;
	assign s_tready  = (state_q == mpa_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	// position of this item
	always_comb begin
		col_rst = s_tuser || (CB'(col_pos_q) >= CB'(w));
		c_e     = col_rst ? '0 : col_pos_q;
		cph_e   = col_rst ? '0 : cph_q;
		oc_e    = col_rst ? '0 : oc_q;
		r_e     = s_tuser ? '0 : row_pos_q;
		rph_e   = s_tuser ? '0 : rph_q;
		orow_e  = s_tuser ? '0 : orow_q;
		rbase_e = s_tuser ? '0 : rbase_q;
		drop    = r_e >= h;
		c_nx    = CB'(c_e) + CB'(1);
		col_wrap = c_nx >= CB'(w);
		win = !drop && (c_nx >= CB'(kw)) && (CB'(r_e) + CB'(1) >= CB'(kh))
			&& cph_e == 4'd0 && rph_e == 4'd0;
		koff   = (AW+1)'(32'(kh - KB'(1)) * MAX_WIDTH);
		wstart = ((AW+1)'(rbase_e) >= koff) ? (AW+1)'(rbase_e) - koff
			: (AW+1)'(rbase_e) + (AW+1)'(DEPTH) - koff;
		rb_nx  = (AW+1)'(rbase_e) + (AW+1)'(MAX_WIDTH);
		if (rb_nx >= (AW+1)'(DEPTH)) begin
			rb_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= 11'd32;
			in_height_q <= 11'd32;
			kernel_w_q  <= 4'd2;
			kernel_h_q  <= 4'd2;
			stride_w_q  <= 4'd2;
			stride_h_q  <= 4'd2;
			col_pos_q   <= '0;
			cph_q       <= '0;
			oc_q        <= '0;
			row_pos_q   <= '0;
			rph_q       <= '0;
			orow_q      <= '0;
			rbase_q     <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				mpa_pkg::REG_IN_WIDTH:  in_width_q  <= cfg_data;
				mpa_pkg::REG_IN_HEIGHT: in_height_q <= cfg_data;
				mpa_pkg::REG_KERNEL_W:  kernel_w_q  <= cfg_data[3:0];
				mpa_pkg::REG_KERNEL_H:  kernel_h_q  <= cfg_data[3:0];
				mpa_pkg::REG_STRIDE_W:  stride_w_q  <= cfg_data[3:0];
				mpa_pkg::REG_STRIDE_H:  stride_h_q  <= cfg_data[3:0];
				default: ;
			endcase
			col_pos_q <= '0;
			cph_q     <= '0;
			oc_q      <= '0;
			row_pos_q <= '0;
			rph_q     <= '0;
			orow_q    <= '0;
			rbase_q   <= '0;
		end else if (accept) begin
			if (drop) begin
				col_pos_q <= c_e;
				cph_q     <= cph_e;
				oc_q      <= oc_e;
				row_pos_q <= r_e;
				rph_q     <= rph_e;
				orow_q    <= orow_e;
				rbase_q   <= rbase_e;
			end else if (col_wrap) begin
				col_pos_q <= '0;
				cph_q     <= '0;
				oc_q      <= '0;
				row_pos_q <= r_e + 11'd1;
				rbase_q   <= AW'(rb_nx);
				if (CB'(r_e) + CB'(2) <= CB'(kh)) begin
					rph_q  <= '0;
					orow_q <= '0;
				end else if (rph_e == sh - 4'd1) begin
					rph_q  <= '0;
					orow_q <= orow_e + 10'd1;
				end else begin
					rph_q  <= rph_e + 4'd1;
					orow_q <= orow_e;
				end
			end else begin
				col_pos_q <= XW'(c_nx);
				row_pos_q <= r_e;
				rph_q     <= rph_e;
				orow_q    <= orow_e;
				rbase_q   <= rbase_e;
				if (CB'(c_e) + CB'(2) <= CB'(kw)) begin
					cph_q <= '0;
					oc_q  <= '0;
				end else if (cph_e == sw - 4'd1) begin
					cph_q <= '0;
					oc_q  <= oc_e + 10'd1;
				end else begin
					cph_q <= cph_e + 4'd1;
					oc_q  <= oc_e;
				end
			end
		end
	end

	// window scan sequencer
	assign kx_end  = (kx_q == kw - KB'(1));
	assign ky_end  = (ky_q == kh - KB'(1));
	assign rd_addr = row_addr_q + AW'(c0_q) + AW'(kx_q);
	assign out_load = (state_q == mpa_pkg::ST_EMIT) && (!m_valid_q || m_tready);

	always_comb begin
		ra_nx = (AW+1)'(row_addr_q) + (AW+1)'(MAX_WIDTH);
		if (ra_nx >= (AW+1)'(DEPTH)) begin
			ra_nx = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpa_pkg::ST_IDLE:  if (accept && win) state_d = mpa_pkg::ST_SCAN;
			mpa_pkg::ST_SCAN:  if (kx_end && ky_end) state_d = mpa_pkg::ST_FLUSH;
			mpa_pkg::ST_FLUSH: state_d = mpa_pkg::ST_EMIT;
			mpa_pkg::ST_EMIT:  if (out_load) state_d = mpa_pkg::ST_IDLE;
			default:           state_d = mpa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpa_pkg::ST_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == mpa_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mpa_pkg::ST_IDLE && accept && win) begin
			c0_q       <= XW'(c_nx - CB'(kw));
			row_addr_q <= AW'(wstart);
			kx_q       <= '0;
			ky_q       <= '0;
			win_ocol_q <= oc_e;
			win_orow_q <= orow_e;
			win_last_q <= (CB'(c_e) + CB'(sw) >= CB'(w)) && (CB'(r_e) + CB'(sh) >= CB'(h));
		end else if (state_q == mpa_pkg::ST_SCAN) begin
			if (kx_end) begin
				kx_q       <= '0;
				ky_q       <= ky_q + KB'(1);
				row_addr_q <= AW'(ra_nx);
			end else begin
				kx_q <= kx_q + KB'(1);
			end
		end
		kx_s1 <= kx_q;
		ky_s1 <= ky_q;
		if (vld_s1 && ((kx_s1 == '0 && ky_s1 == '0) || $signed(rd_data) > $signed(best_q))) begin
			best_q <= rd_data;
			bkx_q  <= kx_s1;
			bky_q  <= ky_s1;
		end
	end

	mpa_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk    (clk),
		.wr_en  (accept && !drop),
		.wr_addr(rbase_e + AW'(c_e)),
		.wr_data(s_tdata[SAMPLE_BITS-1:0]),
		.rd_en  (state_q == mpa_pkg::ST_SCAN),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_max_q  <= best_q;
			o_acol_q <= 4'(32'(bkx_q) + 1);
			o_arow_q <= 4'(32'(bky_q) + 1);
			o_ocol_q <= win_ocol_q;
			o_orow_q <= win_orow_q;
			o_last_q <= win_last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OTW'({o_orow_q, o_ocol_q, o_arow_q, o_acol_q, o_max_q});
	assign m_tlast  = o_last_q;

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == mpa_pkg::ST_SCAN || state_q == mpa_pkg::ST_FLUSH))
		else $error("read data arrives outside a window scan");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mpa_pkg::ST_SCAN |-> (kx_q < kw && ky_q < kh))
		else $error("scan counters leave the window");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("window result not presented");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mpa_pkg::ST_IDLE |-> CB'(col_pos_q) < CB'(w))
		else $error("column position past row width");

endmodule

/* bench/max_pool_2d_argmax_test.sv */
// Self-checking bench for max_pool_2d_argmax: streams sample planes under many
// window geometries; checks each maximum, argmax, out position and last flag.
// Depends on mpa_pkg and the max_pool_2d_argmax RTL only.
`timescale 1ns / 1ps

module max_pool_2d_argmax_test;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_KERNEL  = 8;
	localparam int SCAN_SLACK  = MAX_KERNEL * MAX_KERNEL + 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int ITEM_TARGET = 220;
	localparam int CALM_TAIL   = 60;

	typedef struct packed {
		logic [15:0] max_value;
		logic [3:0]  arg_col;
		logic [3:0]  arg_row;
		logic [9:0]  out_col;
		logic [9:0]  out_row;
		logic        plane_last;
	} window_t;

	typedef struct packed {
		logic [mpa_pkg::CFG_IDX_BITS-1:0]  idx;
		logic [mpa_pkg::CFG_DATA_BITS-1:0] data;
	} reg_write_t;

	typedef enum {VAL_WIDE, VAL_NARROW, VAL_EDGE} val_style_t;

	class pool_ledger;
		logic [15:0] line_store [MAX_KERNEL][MAX_WIDTH];
		int unsigned cfg_reg [mpa_pkg::REG_COUNT];
		int unsigned col_pos, row_pos;
		window_t pending_windows [$];
		int mismatches;

		function new();
			cfg_reg = '{32, 32, 2, 2, 2, 2};
			col_pos = 0;
			row_pos = 0;
			mismatches = 0;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(logic [mpa_pkg::CFG_IDX_BITS-1:0] idx,
				logic [mpa_pkg::CFG_DATA_BITS-1:0] data);
			if (idx >= mpa_pkg::REG_COUNT) return;
			cfg_reg[idx] = (idx < mpa_pkg::REG_KERNEL_W) ? data : data[3:0];
			col_pos = 0;
			row_pos = 0;
		endfunction

		function void take_sample(logic [15:0] smp, logic starts);
			int unsigned w, h, kw, kh, sw, sh, c, r, c0, r0, bc, br;
			logic signed [15:0] best, v;
			window_t win;
			w = clip(cfg_reg[mpa_pkg::REG_IN_WIDTH], 1, MAX_WIDTH);
			h = clip(cfg_reg[mpa_pkg::REG_IN_HEIGHT], 1, 4095);
			kw = clip(cfg_reg[mpa_pkg::REG_KERNEL_W], 1, MAX_KERNEL);
			kh = clip(cfg_reg[mpa_pkg::REG_KERNEL_H], 1, MAX_KERNEL);
			sw = clip(cfg_reg[mpa_pkg::REG_STRIDE_W], 1, 15);
			sh = clip(cfg_reg[mpa_pkg::REG_STRIDE_H], 1, 15);
			if (starts) begin
				col_pos = 0;
				row_pos = 0;
			end
			if (col_pos >= w) col_pos = 0;
			if (row_pos >= h) return;
			c = col_pos;
			r = row_pos;
			line_store[r % MAX_KERNEL][c] = smp;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (c + 1 < kw || r + 1 < kh) return;
			c0 = c + 1 - kw;
			r0 = r + 1 - kh;
			if (c0 % sw != 0 || r0 % sh != 0) return;
			bc = 0;
			br = 0;
			best = line_store[r0 % MAX_KERNEL][c0];
			for (int ky = 0; ky < kh; ky++) begin
				for (int kx = 0; kx < kw; kx++) begin
					v = line_store[(r0 + ky) % MAX_KERNEL][c0 + kx];
					if (v > best) begin
						best = v;
						bc = kx;
						br = ky;
					end
				end
			end
			win.max_value = best;
			win.arg_col = 4'(bc + 1);
			win.arg_row = 4'(br + 1);
			win.out_col = 10'(c0 / sw);
			win.out_row = 10'(r0 / sh);
			win.plane_last = (c0 / sw == (w - kw) / sw) && (r0 / sh == (h - kh) / sh);
			pending_windows.push_back(win);
		endfunction

		function void match_window(logic [47:0] data, logic last);
			window_t got, want;
			got.max_value = data[15:0];
			got.arg_col = data[19:16];
			got.arg_row = data[23:20];
			got.out_col = data[33:24];
			got.out_row = data[43:34];
			got.plane_last = last;
			if (pending_windows.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected window max %0d arg (%0d,%0d) out (%0d,%0d) last %0b",
						$time, $signed(got.max_value), got.arg_col, got.arg_row,
						got.out_col, got.out_row, got.plane_last);
				mismatches++;
				return;
			end
			want = pending_windows.pop_front();
			if (got.max_value !== want.max_value || got.arg_col !== want.arg_col ||
					got.arg_row !== want.arg_row || got.out_col !== want.out_col ||
					got.out_row !== want.out_row || got.plane_last !== want.plane_last) begin
				if (mismatches < 10) begin
					$display("%0t: window mismatch", $time);
					$display("  expected max %0d arg (%0d,%0d) out (%0d,%0d) last %0b",
						$signed(want.max_value), want.arg_col, want.arg_row,
						want.out_col, want.out_row, want.plane_last);
					$display("  actual   max %0d arg (%0d,%0d) out (%0d,%0d) last %0b",
						$signed(got.max_value), got.arg_col, got.arg_row,
						got.out_col, got.out_row, got.plane_last);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [15:0]                       s_tdata;
	logic                              s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [47:0]                       m_tdata;
	logic                              m_tlast;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [mpa_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [mpa_pkg::CFG_DATA_BITS-1:0] cfg_data;

	pool_ledger ledger = new();
	reg_write_t reg_batch [$];
	bit src_idle = 0;
	bit sink_idle = 0;
	int samples_sent = 0;
	int quiet_cycles = 0;
	int unsigned geo_w, geo_h;

	max_pool_2d_argmax dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) ledger.match_window(m_tdata, m_tlast);
		if (s_tvalid && s_tready) ledger.take_sample(s_tdata, s_tuser);
		if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL max_pool_2d_argmax");
			$finish;
		end
	end

	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_idle && $urandom_range(0, 4) == 0) begin
				m_tready = 0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_tready = 1;
		end
	end

	function automatic logic [15:0] next_sample(val_style_t style);
		case (style)
			VAL_NARROW: return 16'($urandom_range(0, 6) - 3);
			VAL_EDGE: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void queue_reg(logic [mpa_pkg::CFG_IDX_BITS-1:0] idx, int unsigned v);
		reg_write_t wr;
		wr.idx = idx;
		wr.data = mpa_pkg::CFG_DATA_BITS'(v);
		if (idx >= mpa_pkg::REG_KERNEL_W && $urandom_range(0, 1) == 1)
			wr.data[mpa_pkg::CFG_DATA_BITS-1:4] = 7'($urandom);
		reg_batch.push_back(wr);
	endfunction

	// All tasks below start and end just after a falling edge.
	task automatic send_sample(input logic [15:0] smp, input logic starts);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = smp;
		s_tuser = starts;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_plane(input int count, input val_style_t style, input bit with_start);
		for (int i = 0; i < count; i++)
			send_sample(next_sample(style),
				(with_start && i == 0) || $urandom_range(0, 99) == 0);
	endtask

	task automatic wait_results_done();
		s_tvalid = 0;
		while (ledger.pending_windows.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		wait_results_done();
		repeat (SCAN_SLACK) @(negedge clk);
	endtask

	task automatic flush_regs();
		reg_write_t wr;
		while (reg_batch.size() != 0) begin
			wr = reg_batch.pop_front();
			cfg_valid = 1;
			cfg_index = wr.idx;
			cfg_data = wr.data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid = 0;
	endtask

	task automatic set_geometry(input int unsigned w, h, kw, kh, sw, sh);
		drain();
		queue_reg(mpa_pkg::REG_IN_WIDTH, w);
		queue_reg(mpa_pkg::REG_IN_HEIGHT, h);
		queue_reg(mpa_pkg::REG_KERNEL_W, kw);
		queue_reg(mpa_pkg::REG_KERNEL_H, kh);
		queue_reg(mpa_pkg::REG_STRIDE_W, sw);
		queue_reg(mpa_pkg::REG_STRIDE_H, sh);
		flush_regs();
		geo_w = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
		geo_h = (h == 0) ? 1 : h;
	endtask

	function automatic int unsigned pick_kernel(int unsigned dim);
		case ($urandom_range(0, 15))
			0: return 0;
			1: return $urandom_range(9, 15);
			default: return $urandom_range(1, dim < MAX_KERNEL ? dim : MAX_KERNEL);
		endcase
	endfunction

	function automatic int unsigned pick_stride();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(5, 15);
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	initial begin
		int loop_start, plane_items;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// extremes and ties in a 4x2 plane, 2x2 windows; hold mid-plane until drained
		set_geometry(4, 2, 2, 2, 2, 2);
		send_sample(16'h8000, 1);
		send_sample(16'h7fff, 0);
		send_sample(16'hffff, 0);
		send_sample(16'h0000, 0);
		send_sample(16'h7fff, 0);
		send_sample(16'h0000, 0);
		wait_results_done();
		send_sample(16'h0000, 0);
		send_sample(16'h0000, 0);
		send_sample(16'h1234, 0);

		// zero sizes act as one; drop samples past the plane end
		set_geometry(0, 0, 0, 0, 0, 0);
		send_sample(16'h7fff, 1);
		send_sample(16'h8000, 0);
		send_sample(16'h8000, 1);

		// plane smaller than the window
		set_geometry(2, 2, 3, 3, 1, 1);
		send_plane(4, VAL_EDGE, 1);

		// a register write restarts the position mid-plane
		set_geometry(3, 3, 2, 2, 1, 1);
		send_plane(4, VAL_WIDE, 1);
		drain();
		queue_reg(mpa_pkg::REG_STRIDE_H, 1);
		flush_regs();
		send_plane(9, VAL_NARROW, 0);
		drain();
		queue_reg(mpa_pkg::REG_COUNT, $urandom_range(0, 2047));
		flush_regs();

		// widest row and largest window
		src_idle = 1;
		sink_idle = 1;
		set_geometry(2047, 1, 8, 1, 15, 1);
		send_plane(120, VAL_WIDE, 1);
		set_geometry(8, 8, 15, 12, 1, 1);
		send_plane(64, VAL_NARROW, 1);

		loop_start = samples_sent;
		while (samples_sent - loop_start < ITEM_TARGET) begin
			int unsigned w, h;
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			set_geometry(w, h, pick_kernel(w), pick_kernel(h), pick_stride(), pick_stride());
			if (samples_sent - loop_start > ITEM_TARGET - CALM_TAIL) begin
				src_idle = 0;
				sink_idle = 0;
			end else begin
				src_idle = $urandom_range(0, 2) != 0;
				sink_idle = $urandom_range(0, 2) != 0;
			end
			plane_items = geo_w * geo_h;
			repeat ($urandom_range(1, 3)) begin
				val_style_t style;
				style = val_style_t'($urandom_range(0, 2));
				case ($urandom_range(0, 9))
					7: send_plane($urandom_range(1, plane_items), style, 1);
					8: send_plane(plane_items + $urandom_range(1, 4), style, 1);
					9: send_plane($urandom_range(1, 4), style, 0);
					default: send_plane(plane_items, style, 1);
				endcase
			end
		end

		drain();
		if (ledger.mismatches == 0)
			$display("PASS max_pool_2d_argmax");
		else
			$display("FAIL max_pool_2d_argmax");
		$finish;
	end

endmodule
